/* hdl/ipv6_neighbor_advert_composer_assert.svh */
// Assertion macros for the composer RTL.
`ifndef IPV6_NEIGHBOR_ADVERT_COMPOSER_ASSERT_SVH
`define IPV6_NEIGHBOR_ADVERT_COMPOSER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define IPV6NA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define IPV6NA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hdl/ipv6na_pkg.sv */
package ipv6na_pkg;

    // Fixed header values of the advertisement frame.
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86dd;
    localparam logic [7:0]  IP_VER_TC      = 8'h60;
    localparam logic [15:0] PAYLOAD_LEN    = 16'd32;
    localparam logic [7:0]  NEXT_HDR_ICMP  = 8'd58;
    localparam logic [7:0]  HOP_LIMIT      = 8'd255;
    localparam logic [7:0]  ICMP_TYPE_NA   = 8'd136;
    localparam logic [7:0]  ICMP_CODE      = 8'd0;
    localparam logic [7:0]  OPT_TLLA       = 8'd2;
    localparam logic [7:0]  OPT_LEN        = 8'd1;

    // Beat layout of the frame.
    localparam int          BEATS          = 11;
    localparam logic [3:0]  LAST_BEAT      = 4'(BEATS - 1);
    localparam logic [3:0]  FULL_BYTES     = 4'd8;
    localparam logic [3:0]  LAST_BYTES     = 4'd6;

    // Checksum accumulation: eight steps of four 16-bit words each.
    localparam int          SUM_STEPS      = 8;
    localparam int          STEP_W         = $clog2(SUM_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_STEPS - 1);
    localparam int          ACC_W          = 21;
    localparam logic [15:0] ONES           = 16'hffff;

    // Sum of the constant words: upper-layer length, next header,
    // type and code, and the option type and length.
    localparam logic [15:0] CK_BIAS = PAYLOAD_LEN + {8'h00, NEXT_HDR_ICMP}
                                    + {ICMP_TYPE_NA, ICMP_CODE} + {OPT_TLLA, OPT_LEN};

    typedef struct packed {
        logic [31:0] flags_word;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [63:0] src_ip_high;
        logic [63:0] src_ip_low;
        logic [63:0] dst_ip_high;
        logic [63:0] dst_ip_low;
    } t_req;

    typedef struct packed {
        t_req        req;
        logic [15:0] checksum;
    } t_desc;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SUM,
        FS_PUSH
    } t_front_state;

endpackage

/* hdl/ipv6na_req_if.sv */
// Request channel: one word is one advertisement request.
interface ipv6na_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] flags_word;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [63:0] src_ip_high;
    logic [63:0] src_ip_low;
    logic [63:0] dst_ip_high;
    logic [63:0] dst_ip_low;

    modport source (
        output valid, flags_word, src_mac, dst_mac,
               src_ip_high, src_ip_low, dst_ip_high, dst_ip_low,
        input  ready
    );
    modport sink (
        input  valid, flags_word, src_mac, dst_mac,
               src_ip_high, src_ip_low, dst_ip_high, dst_ip_low,
        output ready
    );
endinterface

/* hdl/ipv6na_beat_if.sv */
// Frame channel: one word is one 64-bit beat of the frame.
interface ipv6na_beat_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_word;
    logic [3:0]  valid_bytes;
    logic        last_beat;

    modport source (output valid, frame_word, valid_bytes, last_beat, input ready);
    modport sink   (input valid, frame_word, valid_bytes, last_beat, output ready);
endinterface

/* hdl/ipv6na_desc_if.sv */
// Internal channel: a request together with its finished checksum.
interface ipv6na_desc_if;
    logic              valid;
    logic              ready;
    ipv6na_pkg::t_desc desc;

    modport source (output valid, desc, input ready);
    modport sink   (input valid, desc, output ready);
endinterface

/* hdl/ipv6na_front.sv */
// Front end: takes requests and works out the ICMPv6 checksum.
module ipv6na_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv6na_req_if.sink    i_req,
    ipv6na_desc_if.source o_desc
);

    ipv6na_pkg::t_front_state r_state, n_state;
    logic [ipv6na_pkg::STEP_W-1:0] r_step, n_step;
    logic [ipv6na_pkg::ACC_W-1:0]  r_acc, n_acc;
    ipv6na_pkg::t_req              r_req;
    logic                          load;
    logic [63:0]                   chunk;
    logic [ipv6na_pkg::ACC_W-1:0]  chunk_sum;
    logic [16:0]                   fold1;
    logic [15:0]                   fold2;

    // Pick the four words added in the current step. The target address
    // repeats the source address, so that address is summed twice.
    always_comb begin
        unique case (r_step)
            3'd0: chunk = r_req.src_ip_high;
            3'd1: chunk = r_req.src_ip_low;
            3'd2: chunk = r_req.src_ip_high;
            3'd3: chunk = r_req.src_ip_low;
            3'd4: chunk = r_req.dst_ip_high;
            3'd5: chunk = r_req.dst_ip_low;
            3'd6: chunk = {r_req.flags_word, r_req.src_mac[47:16]};
            3'd7: chunk = {r_req.src_mac[15:0], ipv6na_pkg::CK_BIAS, 32'h0};
            default: chunk = 64'h0;
        endcase
    end

    assign chunk_sum = ipv6na_pkg::ACC_W'(chunk[63:48]) + ipv6na_pkg::ACC_W'(chunk[47:32])
                     + ipv6na_pkg::ACC_W'(chunk[31:16]) + ipv6na_pkg::ACC_W'(chunk[15:0]);

    // Fold the carries back in twice; the second fold cannot carry again.
    assign fold1 = 17'(r_acc[15:0]) + 17'(r_acc[ipv6na_pkg::ACC_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    assign o_desc.desc.req      = r_req;
    assign o_desc.desc.checksum = fold2 ^ ipv6na_pkg::ONES;

    // Sequencer: accept, accumulate, hand over to the queue.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_acc        = r_acc;
        i_req.ready  = 1'b0;
        o_desc.valid = 1'b0;
        load         = 1'b0;
        unique case (r_state)
            ipv6na_pkg::FS_IDLE: begin
                i_req.ready = 1'b1;
            end
            ipv6na_pkg::FS_SUM: begin
                n_acc = r_acc + chunk_sum;
                if (r_step == ipv6na_pkg::LAST_STEP) begin
                    n_state = ipv6na_pkg::FS_PUSH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ipv6na_pkg::FS_PUSH: begin
                o_desc.valid = 1'b1;
                i_req.ready  = o_desc.ready;
                if (o_desc.ready) begin
                    n_state = ipv6na_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = ipv6na_pkg::FS_IDLE;
            end
        endcase
        if (i_req.valid && i_req.ready) begin
            load    = 1'b1;
            n_state = ipv6na_pkg::FS_SUM;
            n_step  = '0;
            n_acc   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv6na_pkg::FS_IDLE;
            r_step  <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_acc   <= n_acc;
        end
    end

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req.flags_word  <= i_req.flags_word;
            r_req.src_mac     <= i_req.src_mac;
            r_req.dst_mac     <= i_req.dst_mac;
            r_req.src_ip_high <= i_req.src_ip_high;
            r_req.src_ip_low  <= i_req.src_ip_low;
            r_req.dst_ip_high <= i_req.dst_ip_high;
            r_req.dst_ip_low  <= i_req.dst_ip_low;
        end
    end

endmodule

/* hdl/ipv6na_queue.sv */
// Short queue of finished requests between the front and back ends.
module ipv6na_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv6na_desc_if.sink   i_push,
    ipv6na_desc_if.source o_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipv6na_pkg::t_desc r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              push;
    logic              pop;

    assign i_push.ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.desc   = r_mem[r_rd];
    assign push         = i_push.valid && i_push.ready;
    assign pop          = o_pop.valid && o_pop.ready;

    // Pointer and fill-count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.desc;
        end
    end

endmodule

/* hdl/ipv6na_back.sv */
// Back end: lays the frame out and sends it one beat at a time.
module ipv6na_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv6na_desc_if.sink   i_desc,
    ipv6na_beat_if.source o_beat
);

    ipv6na_pkg::t_desc r_desc;
    logic              r_active, n_active;
    logic [3:0]        r_beat, n_beat;
    logic              r_ov, n_ov;
    logic [63:0]       r_word;
    logic [3:0]        r_bytes;
    logic              r_last;
    logic              adv;
    logic              fin;
    logic              take;
    logic [63:0]       beat_word;

    // Frame bytes of the current beat, earliest wire byte first.
    always_comb begin
        unique case (r_beat)
            4'd0: beat_word = {r_desc.req.dst_mac, r_desc.req.src_mac[47:32]};
            4'd1: beat_word = {r_desc.req.src_mac[31:0], ipv6na_pkg::ETHERTYPE_IPV6,
                               ipv6na_pkg::IP_VER_TC, 8'h00};
            4'd2: beat_word = {16'h0000, ipv6na_pkg::PAYLOAD_LEN, ipv6na_pkg::NEXT_HDR_ICMP,
                               ipv6na_pkg::HOP_LIMIT, r_desc.req.src_ip_high[63:48]};
            4'd3: beat_word = {r_desc.req.src_ip_high[47:0], r_desc.req.src_ip_low[63:48]};
            4'd4: beat_word = {r_desc.req.src_ip_low[47:0], r_desc.req.dst_ip_high[63:48]};
            4'd5: beat_word = {r_desc.req.dst_ip_high[47:0], r_desc.req.dst_ip_low[63:48]};
            4'd6: beat_word = {r_desc.req.dst_ip_low[47:0], ipv6na_pkg::ICMP_TYPE_NA,
                               ipv6na_pkg::ICMP_CODE};
            4'd7: beat_word = {r_desc.checksum, r_desc.req.flags_word,
                               r_desc.req.src_ip_high[63:48]};
            4'd8: beat_word = {r_desc.req.src_ip_high[47:0], r_desc.req.src_ip_low[63:48]};
            4'd9: beat_word = {r_desc.req.src_ip_low[47:0], ipv6na_pkg::OPT_TLLA,
                               ipv6na_pkg::OPT_LEN};
            4'd10: beat_word = {r_desc.req.src_mac, 16'h0000};
            default: beat_word = 64'h0;
        endcase
    end

    // A beat moves into the output register whenever that register is free
    // or being emptied; the next frame is taken as the last beat moves into it.
    assign adv          = r_active && (!r_ov || o_beat.ready);
    assign fin          = adv && (r_beat == ipv6na_pkg::LAST_BEAT);
    assign i_desc.ready = !r_active || fin;
    assign take         = i_desc.valid && i_desc.ready;

    always_comb begin
        n_active = r_active;
        n_beat   = r_beat;
        n_ov     = r_ov;
        if (take) begin
            n_active = 1'b1;
            n_beat   = '0;
        end else if (fin) begin
            n_active = 1'b0;
        end else if (adv) begin
            n_beat = r_beat + 1'b1;
        end
        if (adv) begin
            n_ov = 1'b1;
        end else if (o_beat.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_beat   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_active <= n_active;
            r_beat   <= n_beat;
            r_ov     <= n_ov;
        end
    end

    // Frame descriptor and output payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_desc <= i_desc.desc;
        end
        if (adv) begin
            r_word  <= beat_word;
            r_bytes <= (r_beat == ipv6na_pkg::LAST_BEAT) ? ipv6na_pkg::LAST_BYTES
                                                         : ipv6na_pkg::FULL_BYTES;
            r_last  <= (r_beat == ipv6na_pkg::LAST_BEAT);
        end
    end

    assign o_beat.valid       = r_ov;
    assign o_beat.frame_word  = r_word;
    assign o_beat.valid_bytes = r_bytes;
    assign o_beat.last_beat   = r_last;

endmodule

/* hdl/ipv6_neighbor_advert_composer.sv */
// Builds one 86-byte Ethernet/IPv6/ICMPv6 Neighbor Advertisement frame per
// request and sends it as eleven 64-bit beats, earliest byte in bits 63:56;
// the last beat carries six valid bytes and is zero in bits 15:0. The beat
// sequencer in the back end sends one beat per cycle while the frame output
// keeps ready high. The front end accepts a request, then accumulates the
// checksum in eight steps, four words a step; it then accepts the next
// request in the cycle it hands the current one to the queue. With the
// queue empty and the back end idle, a request passes the checksum steps,
// the queue and the back end's descriptor and output registers before its
// first beat appears. QUEUE_DEPTH (2 to 16) sets how many checksummed
// requests may wait between the two ends.
`include "ipv6_neighbor_advert_composer_assert.svh"

module ipv6_neighbor_advert_composer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv6na_req_if.sink    i_req,
    ipv6na_beat_if.source o_beat
);

    ipv6na_desc_if q_in ();
    ipv6na_desc_if q_out ();

    logic bytes_ok;
    logic req_take;
    logic push_wait;

    // Accept and checksum.
    ipv6na_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_desc  (q_in)
    );

    // Decoupling queue.
    ipv6na_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_in),
        .o_pop   (q_out)
    );

    // Frame layout and beat output.
    ipv6na_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (q_out),
        .o_beat  (o_beat)
    );

    // Handshake terms used by the checks below.
    assign bytes_ok  = !o_beat.valid || (o_beat.valid_bytes == (o_beat.last_beat
                     ? ipv6na_pkg::LAST_BYTES : ipv6na_pkg::FULL_BYTES));
    assign req_take  = i_req.valid && i_req.ready;
    assign push_wait = q_in.valid && !q_in.ready;

    // The byte count must agree with the last-beat marker.
    `IPV6NA_ASSERT_ALWAYS(a_last_bytes, i_clk, i_rst_n, bytes_ok, "wrong beat byte count")

    // A request just taken is still being checksummed in the next cycle.
    `IPV6NA_ASSERT_NEXT(a_one_in_front, i_clk, i_rst_n, req_take, !i_req.ready, "request overlap")

    // A finished request waiting for queue space is held by the front end.
    `IPV6NA_ASSERT_NEXT(a_push_valid, i_clk, i_rst_n, push_wait, q_in.valid, "push withdrawn")
    `IPV6NA_ASSERT_NEXT(a_push_data, i_clk, i_rst_n, push_wait, $stable(q_in.desc), "push changed")

endmodule
